/* sv/polygon_mass_properties_core_macros.svh */
// Assertion macros for the polygon mass properties core.
// Used by the top level only; no other dependencies.
`ifndef POLYGON_MASS_PROPERTIES_CORE_MACROS_SVH
`define POLYGON_MASS_PROPERTIES_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pmp assertion failed");
`define PMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pmp assertion failed");
`else
`define PMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/pmp_pkg.sv */
// Types, codes and saturating helpers for the polygon mass properties core.
// No dependencies.
package pmp_pkg;

	localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic [31:0] density;
		logic last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [63:0] mass;
		logic signed [63:0] center_x;
		logic signed [63:0] center_y;
		logic signed [63:0] inertia;
		logic error;
	} result_t;

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

	typedef enum logic [4:0] {
		OP_E1X_E2Y, OP_E1Y_E2X, OP_E1X_E1X, OP_E2X_E1X, OP_E2X_E2X,
		OP_E1Y_E1Y, OP_E2Y_E1Y, OP_E2Y_E2Y, OP_MOM_X, OP_MOM_Y, OP_INERTIA,
		OP_CEN_X, OP_CEN_Y, OP_DENS_I, OP_RX2, OP_RY2, OP_RX_OX, OP_RY_OY,
		OP_MASS, OP_SHIFT
	} step_t;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	// apply sign to a 128-bit magnitude and clamp to 64 bits
	function automatic logic signed [63:0] sat_mag(input logic neg, input logic [127:0] m);
		if (!neg)
			return (|m[127:63]) ? S64_MAX : m[63:0];
		if ((|m[127:64]) || (m[63] && (|m[62:0])))
			return S64_MIN;
		return 64'd0 - m[63:0];
	endfunction

endpackage

/* sv/polygon_mass_properties_core.sv */
// Polygon mass properties: vertices arrive one word each, the first carrying the
// density, the last flagged. Each vertex from the third on runs eleven products
// through one shared multiplier that forms a 32x32 partial product per cycle,
// holding stall until they are done; the first two vertices run no products. The
// last vertex adds the closing pass: two center divisions on a bit-serial divider,
// one inertia scaling by twelve in eight 16-bit steps plus seven more products,
// before the result word is offered. An error polygon skips the closing pass.
// Depends on pmp_pkg, pmp_mul, pmp_div and the assertion macro header.
`include "polygon_mass_properties_core_macros.svh"
module polygon_mass_properties_core
	import pmp_pkg::*;
#(
	parameter int MAX_VERTICES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vertex_valid,
	output logic vertex_stall,
	input  vertex_t vertex,
	output logic result_valid,
	input  logic result_stall,
	output result_t result
);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

	state_t state_q, state_d;
	step_t step_q;
	logic [CNT_W-1:0] count_q;
	logic too_many_q, last_q, err_q;
	logic signed [31:0] ref_x_q, ref_y_q, prev_x_q, prev_y_q;
	logic [31:0] density_q;
	logic signed [32:0] e1x_q, e1y_q, e2x_q, e2y_q;
	logic signed [63:0] area_q, msx_q, msy_q, isum_q, d_q, t0_q, t1_q, t2_q;
	logic signed [63:0] ox_q, oy_q, mass_q, inertia_q;
	logic mul_kick_q, div_kick_q, div_neg_q;
	result_t result_q;
	logic result_valid_q;

	logic accept, vert_work, err_in, err_end, slot_free;
	logic signed [63:0] opa, opb, r, q_sum, wb_mul;
	logic [127:0] mul_prod, mul_sh, div_num, div_quo;
	logic [65:0] div_den;
	logic mul_done, mul_neg, div_done, wb_en;
	logic signed [63:0] cx_full, cy_full;

	pmp_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_kick_q), .a(opa), .b(opb),
		.done(mul_done), .neg(mul_neg), .prod(mul_prod)
	);

	pmp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_kick_q), .by_twelve(step_q == OP_DENS_I),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
	);

	assign accept = vertex_valid && !vertex_stall;
	assign vert_work = (count_q >= CNT_W'(2)) && (count_q < CNT_MAX);
	assign err_in = (count_q == '0) || too_many_q || (count_q >= CNT_MAX) || (area_q <= 0);
	assign err_end = too_many_q || (area_q <= 0);
	assign slot_free = !result_valid_q || !result_stall;
	assign q_sum = sadd(t1_q, t2_q);

	// operand and scale selection for the shared multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		case (step_q)
			OP_E1X_E2Y: begin opa = 64'(e1x_q); opb = 64'(e2y_q); end
			OP_E1Y_E2X: begin opa = 64'(e1y_q); opb = 64'(e2x_q); end
			OP_E1X_E1X: begin opa = 64'(e1x_q); opb = 64'(e1x_q); end
			OP_E2X_E1X: begin opa = 64'(e2x_q); opb = 64'(e1x_q); end
			OP_E2X_E2X: begin opa = 64'(e2x_q); opb = 64'(e2x_q); end
			OP_E1Y_E1Y: begin opa = 64'(e1y_q); opb = 64'(e1y_q); end
			OP_E2Y_E1Y: begin opa = 64'(e2y_q); opb = 64'(e1y_q); end
			OP_E2Y_E2Y: begin opa = 64'(e2y_q); opb = 64'(e2y_q); end
			OP_MOM_X: begin opa = d_q; opb = 64'(e1x_q) + 64'(e2x_q); end
			OP_MOM_Y: begin opa = d_q; opb = 64'(e1y_q) + 64'(e2y_q); end
			OP_INERTIA: begin opa = d_q; opb = q_sum; end
			OP_DENS_I: begin opa = {32'd0, density_q}; opb = isum_q; end
			OP_RX2: begin opa = 64'(ref_x_q); opb = 64'(ref_x_q); end
			OP_RY2: begin opa = 64'(ref_y_q); opb = 64'(ref_y_q); end
			OP_RX_OX: begin opa = 64'(ref_x_q); opb = ox_q; end
			OP_RY_OY: begin opa = 64'(ref_y_q); opb = oy_q; end
			OP_MASS: begin opa = {32'd0, density_q}; opb = area_q; end
			OP_SHIFT: begin opa = mass_q; opb = q_sum; end
			default: begin opa = '0; opb = '0; end
		endcase
		case (step_q)
			OP_MOM_X, OP_MOM_Y: mul_sh = mul_prod >> 16;
			OP_INERTIA, OP_SHIFT: mul_sh = mul_prod >> 32;
			OP_RX_OX, OP_RY_OY: mul_sh = mul_prod >> 15;
			OP_MASS: mul_sh = mul_prod >> 17;
			default: mul_sh = mul_prod;
		endcase
		wb_mul = sat_mag(mul_neg, mul_sh);
	end

	// divider operands: center numerators are |moment| scaled up by 2^32
	always_comb begin
		case (step_q)
			OP_CEN_X: begin
				div_num = {32'd0, (msx_q[63] ? 64'd0 - msx_q : msx_q), 32'd0};
				div_den = {2'b00, area_q} + {1'b0, area_q, 1'b0};
			end
			OP_CEN_Y: begin
				div_num = {32'd0, (msy_q[63] ? 64'd0 - msy_q : msy_q), 32'd0};
				div_den = {2'b00, area_q} + {1'b0, area_q, 1'b0};
			end
			default: begin
				div_num = mul_prod;
				div_den = '0;
			end
		endcase
	end

	assign wb_en = (mul_done && step_q != OP_DENS_I) || div_done;
	assign r = div_done ? sat_mag(div_neg_q, div_quo) : wb_mul;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (vert_work)
						state_d = S_MUL;
					else if (vertex.last_vertex)
						state_d = err_in ? S_DONE : S_DIV;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					case (step_q)
						OP_DENS_I: state_d = S_DIV;
						OP_INERTIA: begin
							if (!last_q)
								state_d = S_IDLE;
							else
								state_d = err_end ? S_DONE : S_DIV;
						end
						OP_SHIFT: state_d = S_DONE;
						default: state_d = S_MUL;
					endcase
				end
			end
			S_DIV: begin
				if (div_done)
					state_d = (step_q == OP_CEN_X) ? S_DIV : S_MUL;
			end
			S_DONE: begin
				if (slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		vertex_stall = (state_q != S_IDLE);
		result_valid = result_valid_q;
		result = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= OP_E1X_E2Y;
			count_q <= '0;
			too_many_q <= 1'b0;
			last_q <= 1'b0;
			err_q <= 1'b0;
			mul_kick_q <= 1'b0;
			div_kick_q <= 1'b0;
			result_valid_q <= 1'b0;
			ref_x_q <= '0;
			ref_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			density_q <= '0;
			area_q <= '0;
			msx_q <= '0;
			msy_q <= '0;
			isum_q <= '0;
		end else begin
			state_q <= state_d;
			mul_kick_q <= (state_d == S_MUL) && ((state_q != S_MUL) || mul_done);
			div_kick_q <= (state_d == S_DIV) && ((state_q != S_DIV) || div_done);

			if (accept) begin
				last_q <= vertex.last_vertex;
				if (count_q == '0) begin
					ref_x_q <= vertex.vertex_x;
					ref_y_q <= vertex.vertex_y;
					prev_x_q <= vertex.vertex_x;
					prev_y_q <= vertex.vertex_y;
					density_q <= vertex.density;
					area_q <= '0;
					msx_q <= '0;
					msy_q <= '0;
					isum_q <= '0;
					too_many_q <= 1'b0;
					count_q <= CNT_W'(1);
				end else if (count_q >= CNT_MAX) begin
					too_many_q <= 1'b1;
				end else begin
					prev_x_q <= vertex.vertex_x;
					prev_y_q <= vertex.vertex_y;
					count_q <= count_q + CNT_W'(1);
				end
				if (vert_work)
					step_q <= OP_E1X_E2Y;
				else
					step_q <= OP_CEN_X;
				err_q <= err_in;
			end

			if (state_q == S_MUL && mul_done && step_q == OP_INERTIA)
				err_q <= err_end;

			if (wb_en) begin
				step_q <= step_t'(step_q + 5'd1);
				case (step_q)
					OP_MOM_X: msx_q <= sadd(msx_q, r);
					OP_MOM_Y: msy_q <= sadd(msy_q, r);
					OP_INERTIA: isum_q <= sadd(isum_q, r);
					OP_E1Y_E2X: area_q <= sadd(area_q, ssub(t0_q, r));
					default: ;
				endcase
			end

			if (state_q == S_DONE && slot_free) begin
				result_valid_q <= 1'b1;
				count_q <= '0;
				too_many_q <= 1'b0;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			e1x_q <= {prev_x_q[31], prev_x_q} - {ref_x_q[31], ref_x_q};
			e1y_q <= {prev_y_q[31], prev_y_q} - {ref_y_q[31], ref_y_q};
			e2x_q <= {vertex.vertex_x[31], vertex.vertex_x} - {ref_x_q[31], ref_x_q};
			e2y_q <= {vertex.vertex_y[31], vertex.vertex_y} - {ref_y_q[31], ref_y_q};
		end
		if (div_kick_q) begin
			case (step_q)
				OP_CEN_X: div_neg_q <= msx_q[63];
				OP_CEN_Y: div_neg_q <= msy_q[63];
				default: div_neg_q <= mul_neg;
			endcase
		end
		if (wb_en) begin
			case (step_q)
				OP_E1X_E2Y, OP_DENS_I: t0_q <= r;
				OP_E1Y_E2X: d_q <= ssub(t0_q, r);
				OP_E1X_E1X, OP_RX2: t1_q <= r;
				OP_E2X_E1X, OP_E2X_E2X, OP_RY2: t1_q <= sadd(t1_q, r);
				OP_E1Y_E1Y, OP_RX_OX: t2_q <= r;
				OP_E2Y_E1Y, OP_E2Y_E2Y, OP_RY_OY: t2_q <= sadd(t2_q, r);
				OP_CEN_X: ox_q <= r;
				OP_CEN_Y: oy_q <= r;
				OP_MASS: mass_q <= r;
				OP_SHIFT: inertia_q <= sadd(t0_q, r);
				default: ;
			endcase
		end
		if (state_q == S_DONE && slot_free) begin
			if (err_q) begin
				result_q.mass <= '0;
				result_q.center_x <= '0;
				result_q.center_y <= '0;
				result_q.inertia <= '0;
				result_q.error <= 1'b1;
			end else begin
				result_q.mass <= mass_q;
				result_q.center_x <= cx_full;
				result_q.center_y <= cy_full;
				result_q.inertia <= inertia_q;
				result_q.error <= 1'b0;
			end
		end
	end

	assign cx_full = sadd({{16{ref_x_q[31]}}, ref_x_q, 16'd0}, ox_q);
	assign cy_full = sadd({{16{ref_y_q[31]}}, ref_y_q, 16'd0}, oy_q);

	`PMP_ASSERT_NOW(a_mul_in_mul, clk, arst_n, mul_done, state_q == S_MUL)
	`PMP_ASSERT_NOW(a_div_in_div, clk, arst_n, div_done, state_q == S_DIV)
	`PMP_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_MAX)
	`PMP_ASSERT_NEXT(a_done_offers, clk, arst_n, state_q == S_DONE && slot_free,
		result_valid && state_q == S_IDLE)
endmodule

/* sv/pmp_mul.sv */
// Shared 64x64 magnitude multiplier, one 32x32 partial product per cycle.
// Depends on pmp_pkg only through the common style; no types used.
module pmp_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic done,
	output logic neg,
	output logic [127:0] prod
);
	logic [63:0] ma_q, mb_q;
	logic [127:0] acc_q;
	logic [1:0] cnt_q;
	logic busy_q, done_q, neg_q;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [127:0] pp_sh;

	always_comb begin
		pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		pp = pa * pb;
		case (cnt_q)
			2'd0: pp_sh = {64'd0, pp};
			2'd3: pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= a[63] ? 64'd0 - a : a;
			mb_q <= b[63] ? 64'd0 - b : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign neg = neg_q;
	assign prod = acc_q;
endmodule

/* sv/pmp_div.sv */
// Restoring divider, 128-bit magnitude by 66-bit divisor, one bit per cycle; in the
// by_twelve mode it scales by 1/(12*2^16) instead, sixteen quotient bits a step.
// Standalone; no package use.
module pmp_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic by_twelve,
	input  logic [127:0] num,
	input  logic [65:0] den,
	output logic done,
	output logic [127:0] quo
);
	// 12 * 2^16 = 3 * 2^18: shift by 18, then divide by 3 with a reciprocal
	localparam int TWELVE_SHIFT = 18;
	localparam logic [17:0] RECIP3 = 18'd174763;

	logic [127:0] num_q;
	logic [65:0] rem_q, den_q;
	logic [6:0] cnt_q;
	logic busy_q, done_q, by_twelve_q;
	logic [66:0] trial;
	logic [67:0] diff;
	logic ge;
	logic [1:0] r3_q;
	logic [17:0] v3, r3_full;
	logic [35:0] v3m;
	logic [15:0] q3;

	always_comb begin
		trial = {rem_q, num_q[127]};
		diff = {1'b0, trial} - {2'b00, den_q};
		ge = !diff[67];
		v3 = {r3_q, num_q[127:112]};
		v3m = {18'd0, v3} * {18'd0, RECIP3};
		q3 = v3m[34:19];
		r3_full = v3 - ({2'b00, q3} + {1'b0, q3, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			by_twelve_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
			by_twelve_q <= by_twelve;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == (by_twelve_q ? 7'd7 : 7'd127)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= by_twelve ? (num >> TWELVE_SHIFT) : num;
			den_q <= den;
			rem_q <= '0;
			r3_q <= '0;
		end else if (busy_q) begin
			if (by_twelve_q) begin
				// long division by 3, one 16-bit digit per step
				num_q <= {num_q[111:0], q3};
				r3_q <= r3_full[1:0];
			end else begin
				rem_q <= ge ? diff[65:0] : trial[65:0];
				num_q <= {num_q[126:0], ge};
			end
		end
	end

	assign done = done_q;
	assign quo = num_q;
endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for polygon_mass_properties_core: streams polygons,
// predicts mass, center and inertia per polygon and checks each result word.
// Depends on pmp_pkg and the core RTL.
`timescale 1ns / 100ps
module tb_top
	import pmp_pkg::*;
();

	localparam int MAX_VERTS = 8;
	localparam int TAIL_ITEMS = 150;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 6000;

	logic clk, arst_n;
	logic vertex_valid, vertex_stall, result_valid, result_stall;
	vertex_t vertex;
	result_t result;

	polygon_mass_properties_core #(.MAX_VERTICES(MAX_VERTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	vertex_t pending_q[$];
	result_t expected_q[$];
	int fail_count = 0;
	int words_in = 0;
	int tx_gap = 0, rx_gap = 0, holdoff = 0;
	bit holdoff_done = 0;
	int quiet_cycles = 0;

	// polygon accumulation state
	logic signed [63:0] first_x, first_y, last_x, last_y, dens_q;
	logic signed [63:0] twice_area, mom_x, mom_y, second_mom;
	int nverts = 0;
	bit overflowed = 0;

	function automatic logic [63:0] umag(logic signed [63:0] a);
		return a[63] ? 64'd0 - a : a;
	endfunction

	function automatic logic signed [63:0] clamp128(bit neg, logic [127:0] m);
		if (!neg)
			return (m > 128'h7fff_ffff_ffff_ffff) ? S64_MAX : m[63:0];
		if (m > 128'h8000_0000_0000_0000)
			return S64_MIN;
		return 64'd0 - m[63:0];
	endfunction

	function automatic logic signed [63:0] prod_shr(logic signed [63:0] a,
		logic signed [63:0] b, int k);
		logic [127:0] m;
		m = {64'd0, umag(a)} * {64'd0, umag(b)};
		return clamp128(a[63] ^ b[63], m >> k);
	endfunction

	function automatic logic signed [63:0] quot_sat(bit neg, logic [127:0] m,
		logic [127:0] d);
		if (d == 0)
			return 0;
		return clamp128(neg, m / d);
	endfunction

	function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sub_sat(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	// fold one vertex into the polygon; queue a result on the last one
	task automatic accumulate_vertex(vertex_t v);
		logic signed [63:0] vx, vy, e1x, e1y, e2x, e2y, cr, qx, qy;
		logic signed [63:0] ox, oy, dens_i, shift;
		logic [127:0] div3;
		result_t r;
		vx = {{32{v.vertex_x[31]}}, v.vertex_x};
		vy = {{32{v.vertex_y[31]}}, v.vertex_y};
		if (nverts == 0) begin
			first_x = vx; first_y = vy; last_x = vx; last_y = vy;
			dens_q = {32'd0, v.density};
			twice_area = 0; mom_x = 0; mom_y = 0; second_mom = 0;
			overflowed = 0;
			nverts = 1;
		end else if (nverts >= MAX_VERTS) begin
			overflowed = 1;
		end else begin
			if (nverts >= 2) begin
				e1x = last_x - first_x; e1y = last_y - first_y;
				e2x = vx - first_x; e2y = vy - first_y;
				cr = sub_sat(prod_shr(e1x, e2y, 0), prod_shr(e1y, e2x, 0));
				qx = add_sat(add_sat(prod_shr(e1x, e1x, 0), prod_shr(e2x, e1x, 0)),
					prod_shr(e2x, e2x, 0));
				qy = add_sat(add_sat(prod_shr(e1y, e1y, 0), prod_shr(e2y, e1y, 0)),
					prod_shr(e2y, e2y, 0));
				twice_area = add_sat(twice_area, cr);
				mom_x = add_sat(mom_x, prod_shr(cr, e1x + e2x, 16));
				mom_y = add_sat(mom_y, prod_shr(cr, e1y + e2y, 16));
				second_mom = add_sat(second_mom, prod_shr(cr, add_sat(qx, qy), 32));
			end
			last_x = vx; last_y = vy;
			nverts++;
		end
		if (!v.last_vertex)
			return;
		r = '0;
		r.error = overflowed || twice_area <= 0;
		if (!r.error) begin
			div3 = {64'd0, twice_area} * 128'd3;
			ox = quot_sat(mom_x[63], {32'd0, umag(mom_x), 32'd0}, div3);
			oy = quot_sat(mom_y[63], {32'd0, umag(mom_y), 32'd0}, div3);
			dens_i = quot_sat(second_mom[63], {64'd0, umag(dens_q)} * {64'd0,
				umag(second_mom)}, 128'd12 << 16);
			shift = add_sat(add_sat(prod_shr(first_x, first_x, 0),
				prod_shr(first_y, first_y, 0)),
				add_sat(prod_shr(first_x, ox, 15), prod_shr(first_y, oy, 15)));
			r.mass = prod_shr(dens_q, twice_area, 17);
			r.center_x = add_sat(first_x * 65536, ox);
			r.center_y = add_sat(first_y * 65536, oy);
			r.inertia = add_sat(dens_i, prod_shr(r.mass, shift, 32));
		end
		expected_q.push_back(r);
		nverts = 0;
		overflowed = 0;
	endtask

	task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] d, bit lst);
		vertex_t v;
		v.vertex_x = x; v.vertex_y = y; v.density = d; v.last_vertex = lst;
		pending_q.push_back(v);
	endtask

	// star-shaped polygon with strictly turning directions; cw reverses order
	task automatic push_star(int n, int scale, bit cw, logic [31:0] d);
		int dx[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
		int dy[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
		int sect[$];
		longint cx, cy, span, rad, px[$], py[$];
		int k;
		for (k = 0; k < 8; k++)
			sect.push_back(k);
		while (sect.size() > n)
			sect.delete($urandom_range(0, sect.size() - 1));
		span = (scale >= 30) ? 0 : (64'sd1 << 31) - (64'sd1 << (scale + 1)) - 1;
		cx = span ? $signed(longint'($urandom_range(0, 2 * span))) - span : 0;
		cy = span ? $signed(longint'($urandom_range(0, 2 * span))) - span : 0;
		foreach (sect[i]) begin
			rad = $urandom_range(1, (1 << scale) - 1);
			px.push_back(cx + dx[sect[i]] * rad);
			py.push_back(cy + dy[sect[i]] * rad);
		end
		for (k = 0; k < n; k++) begin
			int j;
			j = cw ? n - 1 - k : k;
			push_vertex(32'(px[j]), 32'(py[j]), d, k == n - 1);
		end
	endtask

	function automatic logic [31:0] rand_density();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0004_0000);
			default: return $urandom_range(32'h0000_8000, 32'h0002_0000);
		endcase
	endfunction

	task automatic check_field(string name, logic signed [63:0] want,
		logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d actual %0d", $realtime, name,
				want, got);
			fail_count++;
		end
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// sender: advance on acceptance, idle in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_valid <= 0;
			vertex <= '0;
		end else begin
			if (vertex_valid && !vertex_stall) begin
				accumulate_vertex(vertex);
				words_in++;
			end
			if (!vertex_valid || !vertex_stall) begin
				if (tx_gap == 0 && pending_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
					tx_gap = $urandom_range(1, 14);
				if (tx_gap > 0) begin
					tx_gap--;
					vertex_valid <= 0;
				end else if (pending_q.size() > 0) begin
					vertex <= pending_q.pop_front();
					vertex_valid <= 1;
				end else begin
					vertex_valid <= 0;
				end
			end
		end
	end

	// receiver: check results, stall in bursts plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word, expected none actual %p",
						$realtime, result);
					fail_count++;
				end else begin
					result_t want;
					want = expected_q.pop_front();
					check_field("mass", want.mass, result.mass);
					check_field("center_x", want.center_x, result.center_x);
					check_field("center_y", want.center_y, result.center_y);
					check_field("inertia", want.inertia, result.inertia);
					check_field("error", want.error, result.error);
				end
			end
			if (!holdoff_done && words_in >= 600) begin
				holdoff_done = 1;
				holdoff = HOLDOFF_CYCLES;
			end
			if (rx_gap == 0 && pending_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
				rx_gap = $urandom_range(1, 14);
			if (holdoff > 0) begin
				holdoff--;
				result_stall <= 1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				result_stall <= 1;
			end else begin
				result_stall <= 0;
			end
		end
	end

	// watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int n;
		arst_n = 0;
		// directed: degenerate, basic shapes, extremes, too many vertices
		push_vertex(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1);
		push_vertex(0, 0, 32'h0001_0000, 0);
		push_vertex(32'h0001_0000, 0, 0, 1);
		push_vertex(0, 0, 32'h0001_0000, 0);
		push_vertex(32'h0001_0000, 0, 0, 0);
		push_vertex(0, 32'h0001_0000, 0, 1);
		push_vertex(32'h0001_0000, 32'h0001_0000, 32'hffff_ffff, 0);
		push_vertex(32'h0003_0000, 32'h0001_0000, 0, 0);
		push_vertex(32'h0003_0000, 32'h0003_0000, 0, 0);
		push_vertex(32'h0001_0000, 32'h0003_0000, 0, 1);
		push_vertex(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 0);
		push_vertex(32'h7fff_ffff, 32'h8000_0000, 0, 0);
		push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
		push_vertex(32'h8000_0000, 32'h7fff_ffff, 0, 1);
		push_star(3, 8, 1, 32'h0001_0000);
		push_star(8, 12, 0, 32'h0002_0000);
		for (n = 0; n < 9; n++)
			push_vertex(n << 16, (n * n) << 12, 32'h0001_0000, n == 8);
		// random: mostly well-formed polygons, some reversed, some noise
		while (pending_q.size() < 1800) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(1, 12);
					for (int k = 0; k < n; k++)
						push_vertex($urandom, $urandom, $urandom, k == n - 1);
				end
				2: push_star($urandom_range(1, 2), $urandom_range(4, 20), 0, rand_density());
				3: push_star($urandom_range(3, 8), $urandom_range(4, 30), 1, rand_density());
				default: push_star($urandom_range(3, 8),
					($urandom_range(0, 4) == 0) ? $urandom_range(21, 30) : $urandom_range(4, 20),
					0, rand_density());
			endcase
		end
		repeat (9) @(posedge clk);
		arst_n = 1;
		while (pending_q.size() > 0 || vertex_valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
